@@ design/lmd_pkg.sv @@
// Shared types and constants for the label map dilation unit.
`default_nettype none
package lmd_pkg;

  localparam int MaxRowsDef   = 256;
  localparam int MaxColsDef   = 256;
  localparam int LabelBitsDef = 16;
  localparam int MaxKernelDef = 7;

  localparam int ExtLabelBits = 16;     // width of label ports
  localparam int MarkDepth    = 65536;  // one mark bit per 16-bit label
  localparam int MarkAddrBits = 16;
  localparam int TapStride    = 7;      // tap bit m*7+n
  localparam int TapBits      = 49;
  localparam int DimBits      = 9;
  localparam int KernBits     = 3;
  localparam int CfgAddrBits  = 6;
  localparam int CfgDataBits  = 64;

  typedef enum logic [1:0] {
    REQ_MARK = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_KROWS  = 3'd2,
    REG_KCOLS  = 3'd3,
    REG_TAPS   = 3'd4,
    REG_EXPAND = 3'd5
  } reg_e;

  typedef struct packed {
    logic [DimBits-1:0]  image_rows;
    logic [DimBits-1:0]  image_cols;
    logic [KernBits-1:0] kernel_rows;
    logic [KernBits-1:0] kernel_cols;
    logic [TapBits-1:0]  kernel_taps;
    logic                expand_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_MCLR,  // clearing the mark memory after reset
    ST_IDLE,
    ST_RCLR,  // clearing the result image
    ST_SRC,   // source pixel read issued
    ST_CHK,   // source label back, mark read issued
    ST_MARK,  // mark back, grow decision
    ST_TAP,   // one kernel tap: address and checks
    ST_RMW,   // target read back, conditional write
    ST_RDO    // result word on the output
  } state_e;

endpackage
`default_nettype wire

@@ design/lmd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lmd_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/lmd_apb_regs.sv @@
// APB configuration registers of the dilation unit.
`default_nettype none
module lmd_apb_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lmd_pkg::CfgAddrBits-1:0]  paddr,
  input  wire logic [lmd_pkg::CfgDataBits-1:0]  pwdata,
  output logic      [lmd_pkg::CfgDataBits-1:0]  prdata,
  output logic                                  pready,
  output lmd_pkg::cfg_t                         cfg_o
);
  import lmd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[5:3]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_ROWS:   cfg_d.image_rows    = pwdata[DimBits-1:0];
        REG_COLS:   cfg_d.image_cols    = pwdata[DimBits-1:0];
        REG_KROWS:  cfg_d.kernel_rows   = pwdata[KernBits-1:0];
        REG_KCOLS:  cfg_d.kernel_cols   = pwdata[KernBits-1:0];
        REG_TAPS:   cfg_d.kernel_taps   = pwdata[TapBits-1:0];
        REG_EXPAND: cfg_d.expand_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ROWS:   prdata = CfgDataBits'(cfg_q.image_rows);
      REG_COLS:   prdata = CfgDataBits'(cfg_q.image_cols);
      REG_KROWS:  prdata = CfgDataBits'(cfg_q.kernel_rows);
      REG_KCOLS:  prdata = CfgDataBits'(cfg_q.kernel_cols);
      REG_TAPS:   prdata = CfgDataBits'(cfg_q.kernel_taps);
      REG_EXPAND: prdata = CfgDataBits'(cfg_q.expand_enable);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_rows    <= DimBits'(256);
      cfg_q.image_cols    <= DimBits'(256);
      cfg_q.kernel_rows   <= KernBits'(3);
      cfg_q.kernel_cols   <= KernBits'(3);
      cfg_q.kernel_taps   <= TapBits'(511);
      cfg_q.expand_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ design/lmd_ctrl.sv @@
// Sequencer and image/mark memories of the dilation unit.
`default_nettype none
module lmd_ctrl #(
  parameter int MAX_ROWS   = lmd_pkg::MaxRowsDef,
  parameter int MAX_COLS   = lmd_pkg::MaxColsDef,
  parameter int LABEL_BITS = lmd_pkg::LabelBitsDef,
  parameter int MAX_KERNEL = lmd_pkg::MaxKernelDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lmd_pkg::cfg_t                     cfg_i,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [lmd_pkg::ExtLabelBits-1:0]  label_value_i,
  input  wire logic                              mark_set_i,
  output logic                                   out_valid_o,
  output logic      [lmd_pkg::ExtLabelBits-1:0]  out_label_o,
  output logic                                   last_pixel_o
);
  import lmd_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int PIX = MAX_ROWS * MAX_COLS;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int PW  = $clog2(PIX + 1);
  localparam int KL  = (MAX_KERNEL < 7) ? MAX_KERNEL : 7;
  localparam int XW  = RW + 4;
  localparam int YW  = CW + 4;
  localparam int LB  = LABEL_BITS;

  state_e state_q, state_d;

  logic [PW-1:0]           load_pos_q, load_pos_d;
  logic [PW-1:0]           read_pos_q, read_pos_d;
  logic                    ready_q, ready_d;
  logic                    last_q, last_d;
  logic [AW-1:0]           p_q, p_d;
  logic [RW-1:0]           i_q, i_d;
  logic [CW-1:0]           j_q, j_d;
  logic [2:0]              m_q, m_d, n_q, n_d;
  logic [LB-1:0]           s_q, s_d;
  logic [AW-1:0]           q_q, q_d;
  logic [MarkAddrBits-1:0] mclr_q, mclr_d;

  // effective configuration
  logic [RW-1:0]    rows;
  logic [CW-1:0]    cols;
  logic [2:0]       kr, kc, offr, offc;
  logic [RW+CW-1:0] prod;
  logic [PW-1:0]    total;

  always_comb begin
    if (cfg_i.image_rows == '0) rows = RW'(1);
    else if (32'(cfg_i.image_rows) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(cfg_i.image_rows);
    if (cfg_i.image_cols == '0) cols = CW'(1);
    else if (32'(cfg_i.image_cols) > MAX_COLS) cols = CW'(MAX_COLS);
    else cols = CW'(cfg_i.image_cols);
    if (cfg_i.kernel_rows == '0) kr = 3'd1;
    else if (32'(cfg_i.kernel_rows) > KL) kr = 3'(KL);
    else kr = cfg_i.kernel_rows;
    if (cfg_i.kernel_cols == '0) kc = 3'd1;
    else if (32'(cfg_i.kernel_cols) > KL) kc = 3'(KL);
    else kc = cfg_i.kernel_cols;
  end

  assign offr  = (kr - 3'd1) >> 1;
  assign offc  = (kc - 3'd1) >> 1;
  assign prod  = rows * cols;
  assign total = prod[PW-1:0];

  // memories
  logic          src_we, res_we, mk_we;
  logic [AW-1:0] src_waddr, src_raddr, res_waddr, res_raddr;
  logic [LB-1:0] src_wdata, src_rdata, res_wdata, res_rdata;
  logic [MarkAddrBits-1:0] mk_waddr, mk_raddr;
  logic          mk_wdata, mk_rdata;

  lmd_ram #(.Width(LB), .Depth(PIX), .AddrW(AW)) u_src_ram (
    .clk_i, .we_i(src_we), .waddr_i(src_waddr), .wdata_i(src_wdata),
    .raddr_i(src_raddr), .rdata_o(src_rdata)
  );

  lmd_ram #(.Width(LB), .Depth(PIX), .AddrW(AW)) u_res_ram (
    .clk_i, .we_i(res_we), .waddr_i(res_waddr), .wdata_i(res_wdata),
    .raddr_i(res_raddr), .rdata_o(res_rdata)
  );

  lmd_ram #(.Width(1), .Depth(MarkDepth), .AddrW(MarkAddrBits)) u_mark_ram (
    .clk_i, .we_i(mk_we), .waddr_i(mk_waddr), .wdata_i(mk_wdata),
    .raddr_i(mk_raddr), .rdata_o(mk_rdata)
  );

  // request decode
  req_e req;
  logic acc, load_done, rd_ok;
  assign req       = req_e'(req_type_i);
  assign acc       = start && (state_q == ST_IDLE);
  assign load_done = (load_pos_q + PW'(1)) >= total;
  assign rd_ok     = ready_q && (read_pos_q < total);

  // pixel / tap bookkeeping
  logic p_last, i_last, n_last, tap_last, grow;
  assign p_last   = (PW'(p_q) + PW'(1)) == total;
  assign i_last   = i_q == (rows - RW'(1));
  assign n_last   = n_q == (kc - 3'd1);
  assign tap_last = n_last && (m_q == (kr - 3'd1));
  assign grow     = !cfg_i.expand_enable || mk_rdata;

  // target address of the current tap
  logic [XW-1:0]    xs;
  logic [YW-1:0]    ys;
  logic             in_x, in_y, tap_on, centre, tap_hit;
  logic [5:0]       tidx;
  logic [RW+CW-1:0] qsum;
  logic [AW-1:0]    q;

  assign xs     = XW'(i_q) + XW'(m_q) - XW'(offr);
  assign ys     = YW'(j_q) + YW'(n_q) - YW'(offc);
  assign in_x   = !xs[XW-1] && (xs < XW'(rows));
  assign in_y   = !ys[YW-1] && (ys < YW'(cols));
  assign tidx   = 6'(m_q) * 6'(TapStride) + 6'(n_q);
  assign tap_on = cfg_i.kernel_taps[tidx];
  assign tap_hit = in_x && in_y && tap_on;
  assign centre = (m_q == offr) && (n_q == offc);
  assign qsum   = ys[CW-1:0] * rows + xs[RW-1:0];
  assign q      = qsum[AW-1:0];

  logic rmw_win;
  assign rmw_win = (src_rdata == '0) && ((res_rdata == '0) || (s_q < res_rdata));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_MCLR: if (mclr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (req == REQ_LOAD && load_done) state_d = ST_RCLR;
          else if (req == REQ_READ && rd_ok) state_d = ST_RDO;
        end
      end
      ST_RCLR: if (p_last) state_d = ST_SRC;
      ST_SRC:  state_d = ST_CHK;
      ST_CHK: begin
        if (src_rdata != '0) state_d = ST_MARK;
        else state_d = p_last ? ST_IDLE : ST_SRC;
      end
      ST_MARK: begin
        if (grow) state_d = ST_TAP;
        else state_d = p_last ? ST_IDLE : ST_SRC;
      end
      ST_TAP: begin
        if (tap_hit && !centre) state_d = ST_RMW;
        else if (tap_last) state_d = p_last ? ST_IDLE : ST_SRC;
      end
      ST_RMW: begin
        if (tap_last) state_d = p_last ? ST_IDLE : ST_SRC;
        else state_d = ST_TAP;
      end
      ST_RDO:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy        = state_q != ST_IDLE;
    out_valid_o = state_q == ST_RDO;
    out_label_o = ExtLabelBits'(res_rdata);
    last_pixel_o = last_q;

    src_we    = acc && (req == REQ_LOAD) && (load_pos_q < PW'(PIX));
    src_waddr = load_pos_q[AW-1:0];
    src_wdata = LB'(label_value_i);
    src_raddr = (state_q == ST_TAP) ? q : p_q;

    res_raddr = (state_q == ST_TAP) ? q : read_pos_q[AW-1:0];
    res_we    = 1'b0;
    res_waddr = p_q;
    res_wdata = s_q;
    case (state_q)
      ST_RCLR: begin
        res_we    = 1'b1;
        res_wdata = '0;
      end
      ST_MARK: res_we = !grow;
      ST_TAP: begin
        res_we    = tap_hit && centre;
        res_waddr = q;
      end
      ST_RMW: begin
        res_we    = rmw_win;
        res_waddr = q_q;
      end
      default: ;
    endcase

    mk_raddr = MarkAddrBits'(src_rdata);
    if (state_q == ST_MCLR) begin
      mk_we    = 1'b1;
      mk_waddr = mclr_q;
      mk_wdata = 1'b0;
    end else begin
      mk_we    = acc && (req == REQ_MARK);
      mk_waddr = label_value_i;
      mk_wdata = mark_set_i;
    end
  end

  // datapath registers
  logic adv_tap, adv_pix;
  always_comb begin
    load_pos_d = load_pos_q;
    read_pos_d = read_pos_q;
    ready_d    = ready_q;
    last_d     = last_q;
    p_d        = p_q;
    i_d        = i_q;
    j_d        = j_q;
    m_d        = m_q;
    n_d        = n_q;
    s_d        = s_q;
    q_d        = q_q;
    mclr_d     = mclr_q;
    adv_tap    = 1'b0;
    adv_pix    = 1'b0;

    case (state_q)
      ST_MCLR: mclr_d = mclr_q + MarkAddrBits'(1);
      ST_IDLE: begin
        if (start) begin
          case (req)
            REQ_LOAD: begin
              ready_d = 1'b0;
              if (load_done) begin
                load_pos_d = '0;
                read_pos_d = '0;
                p_d        = '0;
              end else begin
                load_pos_d = load_pos_q + PW'(1);
              end
            end
            REQ_READ: begin
              if (rd_ok) begin
                last_d = (read_pos_q + PW'(1)) == total;
                if ((read_pos_q + PW'(1)) == total) begin
                  ready_d    = 1'b0;
                  read_pos_d = '0;
                end else begin
                  read_pos_d = read_pos_q + PW'(1);
                end
              end else if (ready_q) begin
                ready_d    = 1'b0;
                read_pos_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RCLR: begin
        if (p_last) begin
          p_d = '0;
          i_d = '0;
          j_d = '0;
        end else begin
          p_d = p_q + AW'(1);
        end
      end
      ST_CHK: begin
        s_d = src_rdata;
        adv_pix = src_rdata == '0;
      end
      ST_MARK: begin
        m_d = '0;
        n_d = '0;
        adv_pix = !grow;
      end
      ST_TAP: begin
        q_d = q;
        adv_tap = !(tap_hit && !centre);
      end
      ST_RMW: adv_tap = 1'b1;
      default: ;
    endcase

    if (adv_tap) begin
      if (tap_last) begin
        adv_pix = 1'b1;
      end else if (n_last) begin
        n_d = '0;
        m_d = m_q + 3'd1;
      end else begin
        n_d = n_q + 3'd1;
      end
    end

    if (adv_pix) begin
      if (p_last) begin
        ready_d = 1'b1;
      end else begin
        p_d = p_q + AW'(1);
        if (i_last) begin
          i_d = '0;
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_MCLR;
      load_pos_q <= '0;
      read_pos_q <= '0;
      ready_q    <= 1'b0;
      last_q     <= 1'b0;
      p_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      m_q        <= '0;
      n_q        <= '0;
      q_q        <= '0;
      mclr_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      read_pos_q <= read_pos_d;
      ready_q    <= ready_d;
      last_q     <= last_d;
      p_q        <= p_d;
      i_q        <= i_d;
      j_q        <= j_d;
      m_q        <= m_d;
      n_q        <= n_d;
      q_q        <= q_d;
      mclr_q     <= mclr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

endmodule
`default_nettype wire

@@ design/label_map_dilation_unit.sv @@
// Top level of the label map dilation unit.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------------
//  request   | req_type_i, label_value_i, mark_set_i   | taken when start && !busy
//  result    | out_label_o, last_pixel_o               | out_valid_o, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high, 8-byte
//            |                                         | register stride
//
// A mark or a non-final load is taken without leaving idle; a read first reads
// the result memory, then shows the word. The load that completes the image
// starts the dilation: the result memory is cleared entry by entry, then each
// pixel's source label is read and checked; a label that grows walks the
// kernel taps, with a read-modify-write of a neighbor where one is needed, and
// one that does not grow is copied through. The single read port of each image
// memory sets this pace. After reset the mark memory is cleared one entry per
// cycle, busy stays high meanwhile. The receiver of results cannot stall.
`default_nettype none
module label_map_dilation_unit #(
  parameter int MAX_ROWS   = lmd_pkg::MaxRowsDef,
  parameter int MAX_COLS   = lmd_pkg::MaxColsDef,
  parameter int LABEL_BITS = lmd_pkg::LabelBitsDef,
  parameter int MAX_KERNEL = lmd_pkg::MaxKernelDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lmd_pkg::CfgAddrBits-1:0]   paddr,
  input  wire logic [lmd_pkg::CfgDataBits-1:0]   pwdata,
  output logic      [lmd_pkg::CfgDataBits-1:0]   prdata,
  output logic                                   pready,
  // request words
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [lmd_pkg::ExtLabelBits-1:0]  label_value_i,
  input  wire logic                              mark_set_i,
  // result words
  output logic                                   out_valid_o,
  output logic      [lmd_pkg::ExtLabelBits-1:0]  out_label_o,
  output logic                                   last_pixel_o
);
  import lmd_pkg::*;

  cfg_t cfg;

  // register file; the user must write it only while idle, which the block does not enforce
  lmd_apb_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // sequencer with source, result and mark memories
  lmd_ctrl #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
    .LABEL_BITS(LABEL_BITS), .MAX_KERNEL(MAX_KERNEL)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg), .start, .busy,
    .req_type_i, .label_value_i, .mark_set_i,
    .out_valid_o, .out_label_o, .last_pixel_o
  );

endmodule
`default_nettype wire

@@ tb/sv/label_map_dilation_unit_tb.sv @@
// Self-checking testbench for the label map dilation unit.
`timescale 1ns / 1ps
`default_nettype none
module label_map_dilation_unit_tb;
  import lmd_pkg::*;

  localparam int CycleLimit = 3000000;  // mark clear after reset plus many dilations
  localparam int DrainCycles = 40;

  typedef struct {
    logic [15:0] label;
    logic        last;
  } pixel_t;

  // Predicts dilated pixels and checks them in column-major order.
  class dilation_scoreboard;
    logic [15:0]  src_img[65536];
    logic [15:0]  dil_img[65536];
    bit           marks[65536];
    int unsigned  load_pos, read_pos;
    bit           ready;
    logic [8:0]   rows_r, cols_r;
    logic [2:0]   krows_r, kcols_r;
    logic [48:0]  taps_r;
    bit           expand_r;
    pixel_t       pixel_q[$];
    int           errors;

    function new();
      foreach (marks[k]) marks[k] = 0;
      load_pos = 0; read_pos = 0; ready = 0;
      rows_r = 256; cols_r = 256; krows_r = 3; kcols_r = 3;
      taps_r = 511; expand_r = 0; errors = 0;
    endfunction

    function void set_reg(reg_e idx, logic [63:0] v);
      case (idx)
        REG_ROWS:   rows_r = v[8:0];
        REG_COLS:   cols_r = v[8:0];
        REG_KROWS:  krows_r = v[2:0];
        REG_KCOLS:  kcols_r = v[2:0];
        REG_TAPS:   taps_r = v[48:0];
        REG_EXPAND: expand_r = v[0];
        default: ;
      endcase
    endfunction

    function int clip(int v, int hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function int unsigned pixel_count();
      return clip(rows_r, 256) * clip(cols_r, 256);
    endfunction

    function void dilate();
      int rows, cols, kr, kc, offr, offc, x, y, q;
      logic [15:0] s;
      rows = clip(rows_r, 256);
      cols = clip(cols_r, 256);
      kr = clip(krows_r, 7);
      kc = clip(kcols_r, 7);
      offr = (kr - 1) / 2;
      offc = (kc - 1) / 2;
      for (int p = 0; p < rows * cols; p++) dil_img[p] = '0;
      for (int j = 0; j < cols; j++) begin
        for (int i = 0; i < rows; i++) begin
          s = src_img[j * rows + i];
          if (s == 0) continue;
          // unmarked labels pass through when marking is on
          if (expand_r && !marks[s]) begin
            dil_img[j * rows + i] = s;
            continue;
          end
          for (int m = 0; m < kr; m++) begin
            for (int n = 0; n < kc; n++) begin
              x = i - offr + m;
              y = j - offc + n;
              if (x < 0 || x >= rows || y < 0 || y >= cols) continue;
              if (!taps_r[m * 7 + n]) continue;
              q = y * rows + x;
              if (m == offr && n == offc) dil_img[q] = s;
              else if (src_img[q] == 0 && (dil_img[q] == 0 || s < dil_img[q]))
                dil_img[q] = s;
            end
          end
        end
      end
    endfunction

    function void note_input(req_e req, logic [15:0] lab, logic mk);
      int unsigned total;
      pixel_t px;
      total = pixel_count();
      case (req)
        REQ_MARK: marks[lab] = mk;
        REQ_LOAD: begin
          ready = 0;
          if (load_pos < 65536) src_img[load_pos] = lab;
          load_pos++;
          if (load_pos >= total) begin
            dilate();
            load_pos = 0;
            read_pos = 0;
            ready = 1;
          end
        end
        REQ_READ: begin
          if (ready) begin
            if (read_pos >= total) begin
              ready = 0;
              read_pos = 0;
            end else begin
              px.label = dil_img[read_pos];
              px.last = (read_pos + 1 == total);
              pixel_q.push_back(px);
              read_pos++;
              if (px.last) begin
                ready = 0;
                read_pos = 0;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check(logic [15:0] lab, logic last);
      pixel_t px;
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word label=%0h last=%0b", lab, last));
        return;
      end
      px = pixel_q.pop_front();
      if (lab !== px.label)
        report_mismatch($sformatf("out_label %0h, want %0h", lab, px.label));
      if (last !== px.last)
        report_mismatch($sformatf("last_pixel %0b, want %0b", last, px.last));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [CfgDataBits-1:0] pwdata = '0;
  logic [CfgDataBits-1:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [15:0] label_value_i = '0;
  logic        mark_set_i = 0;
  logic        out_valid_o;
  logic [15:0] out_label_o;
  logic        last_pixel_o;

  dilation_scoreboard sb = new();
  int          words_sent = 0;
  int          cycles = 0;
  bit          no_idle = 0;
  int          label_span = 4;

  label_map_dilation_unit u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .req_type_i, .label_value_i, .mark_set_i,
    .out_valid_o, .out_label_o, .last_pixel_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result words cannot be stalled: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) sb.check(out_label_o, last_pixel_o);
  end

  // mostly short gaps, a few long ones; none during a no-idle stretch
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request word; start stays high across back-to-back words
  task automatic send_word(req_e req, logic [15:0] lab, logic mk);
    int g;
    req_type_i <= req;
    label_value_i <= lab;
    mark_set_i <= mk;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_input(req, lab, mk);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // block is idle once all pixels are back and busy has dropped
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pixel_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrBits'(idx) << 3;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_cfg(logic [8:0] rows, logic [8:0] cols, logic [2:0] kr,
                             logic [2:0] kc, logic [63:0] taps, logic expand);
    wait_idle();
    apb_write(REG_ROWS, 64'(rows));
    apb_write(REG_COLS, 64'(cols));
    apb_write(REG_KROWS, 64'(kr));
    apb_write(REG_KCOLS, 64'(kc));
    apb_write(REG_TAPS, taps);
    apb_write(REG_EXPAND, 64'(expand));
  endtask

  // small labels collide often; a few wide ones exercise every bit
  function automatic logic [15:0] pick_label();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return '0;
    if (r < 17) return 16'($urandom_range(1, label_span));
    if (r < 19) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  // marks, a full image, then read back with some noise mixed in
  task automatic run_image();
    int unsigned total;
    repeat ($urandom_range(0, 4))
      send_word(REQ_MARK, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                : 16'($urandom_range(0, label_span)), 1'($urandom));
    total = sb.pixel_count();
    while (sb.load_pos != 0 || !sb.ready) begin
      if ($urandom_range(0, 29) == 0) send_word(REQ_NONE, 16'($urandom), 1'($urandom));
      else if ($urandom_range(0, 29) == 0) send_word(REQ_READ, 16'($urandom), 1'b0);
      else send_word(REQ_LOAD, pick_label(), 1'($urandom));
    end
    for (int unsigned p = 0; p < total; p++) begin
      if ($urandom_range(0, 39) == 0) send_word(REQ_NONE, 16'($urandom), 1'($urandom));
      send_word(REQ_READ, 16'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 3) == 0) send_word(REQ_READ, '0, 1'b0);  // nothing ready
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 2x2 image, default 3x3 kernel with tap bits 0-8 set
    program_cfg(9'd2, 9'd2, 3'd3, 3'd3, 64'd511, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);          // read with nothing ready
    send_word(REQ_NONE, 16'hFFFF, 1'b1);       // unknown type is dropped
    send_word(REQ_MARK, 16'h0, 1'b1);          // background mark, no effect
    send_word(REQ_LOAD, 16'h0, 1'b0);
    send_word(REQ_LOAD, 16'hFFFF, 1'b0);
    send_word(REQ_LOAD, 16'h7, 1'b0);
    send_word(REQ_LOAD, 16'h0, 1'b0);
    repeat (5) send_word(REQ_READ, 16'h0, 1'b0);
    // marking on: label 7 grows, label 3 is copied through
    program_cfg(9'd2, 9'd2, 3'd3, 3'd3, 64'h1EF, 1'b1);  // taps 9 and 14-16 clear, centre tap set
    send_word(REQ_MARK, 16'h7, 1'b1);
    send_word(REQ_MARK, 16'h3, 1'b0);
    send_word(REQ_LOAD, 16'h3, 1'b0);
    send_word(REQ_LOAD, 16'h7, 1'b0);
    send_word(REQ_LOAD, 16'h0, 1'b0);
    send_word(REQ_LOAD, 16'h0, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);
    send_word(REQ_LOAD, 16'h5, 1'b0);          // new image while ready
    send_word(REQ_READ, 16'h0, 1'b0);          // no longer ready
    repeat (3) send_word(REQ_LOAD, 16'h0, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);
    // shrink mid-readout: read position lands past the end
    program_cfg(9'd1, 9'd1, 3'd3, 3'd3, 64'd511, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);
    send_word(REQ_READ, 16'h0, 1'b0);
    // load position left past the end by a shrink
    program_cfg(9'd3, 9'd2, 3'd1, 3'd1, 64'd1, 1'b0);
    repeat (3) send_word(REQ_LOAD, 16'h2, 1'b0);
    program_cfg(9'd1, 9'd2, 3'd1, 3'd1, 64'd1, 1'b0);
    send_word(REQ_LOAD, 16'h9, 1'b0);
    repeat (2) send_word(REQ_READ, 16'h0, 1'b0);

    // extremes: tall strip from clamped sizes with the largest kernel, zero sizes
    label_span = 6;
    program_cfg(9'h1FF, 9'd0, 3'd7, 3'd7, {64{1'b1}}, 1'b0);
    run_image();
    program_cfg(9'd0, 9'd5, 3'd0, 3'd0, 64'd0, 1'b1);
    run_image();
    program_cfg(9'd7, 9'd7, 3'd7, 3'd7, {$urandom, $urandom}, 1'b1);
    run_image();

    // random settings, small images
    while (words_sent < 800) begin
      no_idle = ($urandom_range(0, 3) == 0);
      label_span = $urandom_range(1, 12);
      program_cfg(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 4) == 0) ? {64{1'b1}} : {$urandom, $urandom},
                  1'($urandom));
      repeat ($urandom_range(1, 3)) run_image();
    end
    no_idle = 0;

    start <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/lmd_pkg.sv
design/lmd_ram.sv
design/lmd_apb_regs.sv
design/lmd_ctrl.sv
design/label_map_dilation_unit.sv
tb/sv/label_map_dilation_unit_tb.sv
